// ----- rtl/audio_flanger_interpolated_delay_unit_defines.svh -----
// Assertion macros shared by the flanger RTL.
`ifndef AUDIO_FLANGER_INTERPOLATED_DELAY_UNIT_DEFINES_SVH
`define AUDIO_FLANGER_INTERPOLATED_DELAY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define AFID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define AFID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/afid_pkg.sv -----
package afid_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOG2  = 2'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [15:0] PERIOD_RESET = 16'd1024;
  localparam logic        STEREO_RESET = 1'b0;
  localparam logic [3:0]  BLOG2_RESET  = 4'd10;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic mul_en;
  } afid_tab_ctrl_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } afid_store_ctrl_t;

  typedef struct packed {
    logic mul_en;
    logic wet_en;
  } afid_lane_ctrl_t;

endpackage

// ----- rtl/afid_table.sv -----
module afid_table #(
  parameter int unsigned TABLE_DEPTH = afid_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  afid_pkg::afid_tab_ctrl_t       ctrl_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_i,
  input  logic [31:0]                    wr_data_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd0_addr_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd1_addr_i,
  input  logic [7:0]                     weight_i,
  output logic [31:0]                    offset_o
);
  import afid_pkg::*;

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd0_q;
  logic [31:0] rd1_q;
  logic [8:0]  w0;
  logic [40:0] prod0_d;
  logic [40:0] prod0_q;
  logic [39:0] prod1_d;
  logic [39:0] prod1_q;
  logic [41:0] sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd0_q <= mem[rd0_addr_i];
      rd1_q <= mem[rd1_addr_i];
    end
  end

  assign w0      = 9'd256 - {1'b0, weight_i};
  assign prod0_d = 41'(rd0_q) * 41'(w0);
  assign prod1_d = 40'(rd1_q) * 40'(weight_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
    end
  end

  assign sum      = {1'b0, prod0_q} + {2'b00, prod1_q} + 42'h80;
  assign offset_o = sum[39:8];

endmodule

// ----- rtl/afid_store.sv -----
module afid_store #(
  parameter int unsigned STORE_DEPTH = afid_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  afid_pkg::afid_store_ctrl_t     ctrl_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr_i,
  input  logic [31:0]                    wr_data_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd0_addr_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd1_addr_i,
  output logic [31:0]                    rd0_o,
  output logic [31:0]                    rd1_o,
  output logic                           busy_o
);
  import afid_pkg::*;

  localparam int unsigned SA = $clog2(STORE_DEPTH);
  localparam logic [SA-1:0] LAST = SA'(STORE_DEPTH - 1);

  logic [31:0]   mem [STORE_DEPTH];
  logic [SA-1:0] clr_cnt_q;
  logic [SA-1:0] clr_cnt_d;
  logic          busy_q;
  logic          busy_d;
  logic          we;
  logic [SA-1:0] waddr;
  logic [31:0]   wdata;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + SA'(1);
      if (clr_cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  assign we    = busy_q || ctrl_i.wr_en;
  assign waddr = busy_q ? clr_cnt_q : wr_addr_i;
  assign wdata = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rd0_o <= mem[rd0_addr_i];
      rd1_o <= mem[rd1_addr_i];
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- rtl/afid_lane.sv -----
module afid_lane (
  input  logic                      clk_i,
  input  afid_pkg::afid_lane_ctrl_t ctrl_i,
  input  logic signed [15:0]        s0_i,
  input  logic signed [15:0]        s1_i,
  input  logic [15:0]               frac_i,
  input  logic signed [15:0]        dry_i,
  output logic signed [15:0]        res_o
);
  import afid_pkg::*;

  logic [16:0]        w0;
  logic signed [33:0] prod0_d;
  logic signed [33:0] prod1_d;
  logic signed [33:0] prod0_q;
  logic signed [33:0] prod1_q;
  logic signed [33:0] sum;
  logic signed [33:0] sum_sh;
  logic signed [15:0] wet_q;
  logic signed [20:0] dry_x;
  logic signed [20:0] wet_x;
  logic signed [20:0] acc;
  logic signed [20:0] acc_sh;

  assign w0      = 17'h10000 - {1'b0, frac_i};
  assign prod0_d = s0_i * $signed({1'b0, w0});
  assign prod1_d = s1_i * $signed({1'b0, frac_i});

  assign sum    = prod0_q + prod1_q + 34'sd32768;
  assign sum_sh = sum >>> 16;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
    end
    if (ctrl_i.wet_en) begin
      wet_q <= sum_sh[15:0];
    end
  end

  assign dry_x  = $signed({{5{dry_i[15]}}, dry_i});
  assign wet_x  = $signed({{5{wet_q[15]}}, wet_q});
  assign acc    = dry_x * 21'sd9 + wet_x * 21'sd7 + 21'sd8;
  assign acc_sh = acc >>> 4;
  assign res_o  = acc_sh[15:0];

endmodule

// ----- rtl/audio_flanger_interpolated_delay_unit.sv -----
// Flanger with a table-driven, interpolated delay. A load beat writes one 16.16 delay word
// into the table; it gives no result. A sample beat runs through six steps: table read,
// delay interpolation and store write, store read, the lane multiplies, the wet rounding,
// and the output register. in_stall_o stays high until the result is loaded into the output
// register, which waits while the output side stalls, so no new beat is taken before the
// last sample is through. The two channels are worked by two lanes side by side. After
// reset the delay store is cleared one entry per cycle while in_stall_o stays high;
// configuration writes are taken during that time.
`include "audio_flanger_interpolated_delay_unit_defines.svh"

module audio_flanger_interpolated_delay_unit #(
  parameter int unsigned STORE_DEPTH = afid_pkg::STORE_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = afid_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [afid_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [afid_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [7:0]                        table_index_i,
  input  logic [31:0]                       table_value_i,
  input  logic signed [15:0]                sample_left_i,
  input  logic signed [15:0]                sample_right_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                out_left_o,
  output logic signed [15:0]                out_right_o
);
  import afid_pkg::*;

  localparam int unsigned SA      = $clog2(STORE_DEPTH);
  localparam int unsigned TA      = $clog2(TABLE_DEPTH);
  localparam int unsigned RESET_B = (int'(BLOG2_RESET) < SA) ? int'(BLOG2_RESET) : SA;
  localparam logic [SA-1:0] WPOS_RESET = SA'((1 << RESET_B) - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TAB  = 6'b000010,
    ST_ADR  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_WET  = 6'b010000,
    ST_OUT  = 6'b100000
  } afid_state_e;

  function automatic logic [SA-1:0] len_mask(input logic [3:0] b);
    logic [4:0] be;
    be = {1'b0, b};
    if (b == 4'd0) begin
      be = 5'd1;
    end
    if (be > 5'(SA)) begin
      be = 5'(SA);
    end
    return ~({SA{1'b1}} << be);
  endfunction

  afid_state_e state_q, state_d;

  logic [15:0]        period_q, period_d;
  logic               stereo_q, stereo_d;
  logic [3:0]         blog2_q, blog2_d;
  logic [15:0]        phase_q, phase_d;
  logic [SA-1:0]      wpos_q, wpos_d;
  logic signed [15:0] inl_q;
  logic signed [15:0] inr_q;
  logic [15:0]        frac_q;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_left_q;
  logic signed [15:0] out_right_q;

  logic               in_acc;
  logic               out_load;
  logic               clr_busy;
  logic [SA-1:0]      mask;
  logic [SA-1:0]      pos;
  logic [16:0]        phase_inc;
  logic [TA+7:0]      tw_ext;
  logic               tw_ok;
  logic [TA-1:0]      ti0;
  logic [TA-1:0]      ti1;
  logic [31:0]        offset;
  logic [SA-1:0]      p0;
  logic [SA-1:0]      p1;
  logic [31:0]        rd0;
  logic [31:0]        rd1;
  logic signed [15:0] lane_l;
  logic signed [15:0] lane_r;

  afid_tab_ctrl_t   tab_ctrl;
  afid_store_ctrl_t store_ctrl;
  afid_lane_ctrl_t  lane_ctrl;

  assign in_stall_o = (state_q != ST_IDLE) || clr_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign mask = len_mask(blog2_q);
  assign pos  = wpos_q & mask;

  assign tw_ext = {{TA{1'b0}}, table_index_i};
  assign tw_ok  = tw_ext < (TA + 8)'(TABLE_DEPTH);
  assign ti0    = TA'({{TA{1'b0}}, phase_q[15:8]});
  assign ti1    = ti0 + TA'(1);

  assign p0 = (pos + SA'({{SA{1'b0}}, offset[31:16]})) & mask;
  assign p1 = (p0 + SA'(1)) & mask;

  assign tab_ctrl.wr_en    = in_acc && (opcode_i == OP_LOAD) && tw_ok;
  assign tab_ctrl.rd_en    = in_acc && (opcode_i == OP_SAMPLE);
  assign tab_ctrl.mul_en   = (state_q == ST_TAB);
  assign store_ctrl.wr_en  = (state_q == ST_TAB);
  assign store_ctrl.rd_en  = (state_q == ST_ADR);
  assign lane_ctrl.mul_en  = (state_q == ST_MUL);
  assign lane_ctrl.wet_en  = (state_q == ST_WET);

  afid_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i      (clk_i),
    .ctrl_i     (tab_ctrl),
    .wr_addr_i  (TA'(tw_ext)),
    .wr_data_i  (table_value_i),
    .rd0_addr_i (ti0),
    .rd1_addr_i (ti1),
    .weight_i   (phase_q[7:0]),
    .offset_o   (offset)
  );

  afid_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (store_ctrl),
    .wr_addr_i  (pos),
    .wr_data_i  ({inr_q, inl_q}),
    .rd0_addr_i (p0),
    .rd1_addr_i (p1),
    .rd0_o      (rd0),
    .rd1_o      (rd1),
    .busy_o     (clr_busy)
  );

  afid_lane u_lane_l (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .s0_i   ($signed(rd0[15:0])),
    .s1_i   ($signed(rd1[15:0])),
    .frac_i (frac_q),
    .dry_i  (inl_q),
    .res_o  (lane_l)
  );

  afid_lane u_lane_r (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .s0_i   ($signed(rd0[31:16])),
    .s1_i   ($signed(rd1[31:16])),
    .frac_i (frac_q),
    .dry_i  (inr_q),
    .res_o  (lane_r)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (opcode_i == OP_SAMPLE)) begin
          state_d = ST_TAB;
        end
      end
      ST_TAB:  state_d = ST_ADR;
      ST_ADR:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_WET;
      ST_WET:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign phase_inc = {1'b0, phase_q} + 17'd1;

  always_comb begin
    period_d = period_q;
    stereo_d = stereo_q;
    blog2_d  = blog2_q;
    phase_d  = phase_q;
    wpos_d   = wpos_q;
    if (out_load) begin
      phase_d = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[15:0];
      wpos_d  = (pos - SA'(1)) & mask;
    end
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PERIOD: period_d = cfg_wdata_i;
        CFG_STEREO: stereo_d = cfg_wdata_i[0];
        CFG_BLOG2: begin
          blog2_d = cfg_wdata_i[3:0];
          wpos_d  = len_mask(cfg_wdata_i[3:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= PERIOD_RESET;
      stereo_q    <= STEREO_RESET;
      blog2_q     <= BLOG2_RESET;
      phase_q     <= '0;
      wpos_q      <= WPOS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      stereo_q    <= stereo_d;
      blog2_q     <= blog2_d;
      phase_q     <= phase_d;
      wpos_q      <= wpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      inl_q <= sample_left_i;
      inr_q <= stereo_q ? sample_right_i : '0;
    end
    if (state_q == ST_ADR) begin
      frac_q <= offset[15:0];
    end
    if (out_load) begin
      out_left_q  <= lane_l;
      out_right_q <= stereo_q ? lane_r : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

  `AFID_ASSERT_IMP(a_wpos_in_store, 1'b1, (wpos_q & ~mask) == '0,
                   "write position outside store")
  `AFID_ASSERT_NXT(a_sample_starts, in_acc && (opcode_i == OP_SAMPLE), state_q == ST_TAB,
                   "sample beat did not start")
  `AFID_ASSERT_NXT(a_load_stays, in_acc && (opcode_i == OP_LOAD), state_q == ST_IDLE,
                   "load beat left idle")
  `AFID_ASSERT_IMP(a_out_from_lanes, $rose(out_valid_o), $past(state_q == ST_OUT),
                   "result without work")
  `AFID_ASSERT_IMP(a_mono_right_zero, out_valid_o && !stereo_q, out_right_o == '0,
                   "mono right not zero")

endmodule

// ----- tb/audio_flanger_interpolated_delay_unit_tb.sv -----
module audio_flanger_interpolated_delay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afid_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned MAX_PRINTED = 40;
  localparam int unsigned SEGMENTS = 6;
  localparam int unsigned BEATS_PER_SEGMENT = 210;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_pair_t;

  class flange_tracker;
    logic [31:0]  store_mem [STORE_DEPTH_DEF];
    logic [31:0]  delay_words [TABLE_DEPTH_DEF];
    bit           word_loaded [TABLE_DEPTH_DEF];
    logic [15:0]  sweep_pos;
    logic [15:0]  sweep_len;
    logic         stereo;
    logic [3:0]   blog2;
    int unsigned  head;
    stereo_pair_t pending_mixes[$];
    int unsigned  n_errors;

    function new();
      foreach (store_mem[i]) begin
        store_mem[i] = '0;
      end
      foreach (delay_words[i]) begin
        delay_words[i] = '0;
        word_loaded[i] = 1'b0;
      end
      sweep_pos = '0;
      sweep_len = PERIOD_RESET;
      stereo = STEREO_RESET;
      blog2 = BLOG2_RESET;
      head = span() - 1;
      n_errors = 0;
    endfunction

    function int unsigned span();
      int unsigned len;
      len = 1 << ((blog2 == 4'd0) ? 1 : blog2);
      while (len > STORE_DEPTH_DEF) begin
        len = len >> 1;
      end
      return len;
    endfunction

    // Index of a table word that the next sample beat would read before it was loaded.
    function int missing_word();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = sweep_pos[15:8];
      hi = lo + 8'd1;
      if (!word_loaded[lo]) begin
        return int'(lo);
      end
      if (!word_loaded[hi]) begin
        return int'(hi);
      end
      return -1;
    endfunction

    function logic signed [15:0] mix(logic signed [15:0] s0, logic signed [15:0] s1,
                                     logic [15:0] frac, logic signed [15:0] dry);
      longint a;
      longint b;
      longint f;
      longint d;
      longint wet;
      longint sum;
      a = s0;
      b = s1;
      f = frac;
      d = dry;
      wet = (a * (65536 - f) + b * f + 32768) >>> 16;
      sum = (9 * d + 7 * wet + 8) >>> 4;
      return sum[15:0];
    endfunction

    function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PERIOD: begin
          sweep_len = data[15:0];
        end
        CFG_STEREO: begin
          stereo = data[0];
        end
        CFG_BLOG2: begin
          blog2 = data[3:0];
          head = span() - 1;
        end
        default: ;
      endcase
    endfunction

    function void take_beat(logic op, logic [7:0] idx, logic [31:0] word,
                            logic signed [15:0] in_l, logic signed [15:0] in_r);
      logic [7:0]         lo;
      logic [7:0]         hi;
      int unsigned        wt;
      int unsigned        mask;
      int unsigned        pos;
      int unsigned        p0;
      int unsigned        p1;
      int unsigned        nxt;
      longint unsigned    acc;
      logic [31:0]        offset;
      logic signed [15:0] dry_r;
      stereo_pair_t       res;
      if (op == OP_LOAD) begin
        delay_words[idx] = word;
        word_loaded[idx] = 1'b1;
        return;
      end
      lo = sweep_pos[15:8];
      hi = lo + 8'd1;
      wt = sweep_pos[7:0];
      acc = delay_words[lo] * (64'd256 - wt) + delay_words[hi] * 64'(wt) + 64'h80;
      offset = 32'(acc >> 8);
      mask = span() - 1;
      pos = head & mask;
      dry_r = stereo ? in_r : 16'sd0;
      store_mem[pos] = {dry_r, in_l};
      p0 = (pos + offset[31:16]) & mask;
      p1 = (p0 + 1) & mask;
      res.left = mix(store_mem[p0][15:0], store_mem[p1][15:0], offset[15:0], in_l);
      res.right = stereo ? mix(store_mem[p0][31:16], store_mem[p1][31:16], offset[15:0], dry_r)
                         : 16'sd0;
      pending_mixes.push_back(res);
      nxt = sweep_pos + 1;
      if (nxt >= sweep_len) begin
        nxt = 0;
      end
      sweep_pos = 16'(nxt);
      head = (pos - 1) & mask;
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTED) begin
        $display("%0t: %s", $time, msg);
      end
    endtask

    task compare_output(logic signed [15:0] l, logic signed [15:0] r);
      stereo_pair_t want;
      if (pending_mixes.size() == 0) begin
        report_mismatch($sformatf("output beat %0d/%0d with none outstanding", l, r));
        return;
      end
      want = pending_mixes.pop_front();
      if (l !== want.left) begin
        report_mismatch($sformatf("out_left %0d, predicted %0d", l, want.left));
      end
      if (r !== want.right) begin
        report_mismatch($sformatf("out_right %0d, predicted %0d", r, want.right));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  opcode_i = OP_LOAD;
  logic [7:0]            table_index_i = '0;
  logic [31:0]           table_value_i = '0;
  logic signed [15:0]    sample_left_i = '0;
  logic signed [15:0]    sample_right_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [15:0]    out_left_o;
  logic signed [15:0]    out_right_o;

  flange_tracker flanger;
  bit            quiet = 1'b0;
  int unsigned   idle_cycles = 0;

  audio_flanger_interpolated_delay_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      flanger.compare_output(out_left_o, out_right_o);
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 10);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h0000_0000;
      2: return 32'hFFFF_FFFF;
      default: return {16'($urandom_range(flanger.span())), 16'($urandom())};
    endcase
  endfunction

  function automatic logic [15:0] rand_audio();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(5))
      0: return 16'd1;
      1: return 16'd65280;
      2: return 16'd256;
      3: return 16'd0;
      default: return 16'($urandom_range(65280, 2));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    flanger.apply_cfg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic op, logic [7:0] idx, logic [31:0] word,
                           logic [15:0] l, logic [15:0] r);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    table_index_i <= idx;
    table_value_i <= word;
    sample_left_i <= l;
    sample_right_i <= r;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    flanger.take_beat(op, idx, word, l, r);
  endtask

  // A sample beat never reads a table word that has not been loaded.
  task automatic send_sample(logic [15:0] l, logic [15:0] r);
    int idx;
    idx = flanger.missing_word();
    while (idx >= 0) begin
      send_beat(OP_LOAD, 8'(idx), rand_word(), 16'($urandom()), 16'($urandom()));
      idx = flanger.missing_word();
    end
    send_beat(OP_SAMPLE, 8'($urandom()), $urandom(), l, r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (flanger.pending_mixes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    flanger = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_PERIOD, 16'd3);
    write_reg(CFG_BLOG2, 16'd0);
    write_reg(CFG_SPARE, 16'h0001);
    send_beat(OP_LOAD, 8'd0, 32'h0000_0000, 16'h0000, 16'h0000);
    send_beat(OP_LOAD, 8'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_beat(OP_LOAD, 8'd255, 32'h0001_8000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'h7FFF, 16'h7FFF);
    wait_idle();

    // Stereo reads of words written in mono, with the sweep held at zero.
    write_reg(CFG_STEREO, 16'd1);
    write_reg(CFG_PERIOD, 16'd0);
    send_beat(OP_LOAD, 8'd0, 32'h0000_8000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF);
    wait_idle();

    write_reg(CFG_BLOG2, 16'h000F);
    write_reg(CFG_PERIOD, 16'd65280);
    send_beat(OP_LOAD, 8'd2, 32'h0003_4000, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(rand_audio(), rand_audio());

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      if (seg == 0) begin
        write_reg(CFG_PERIOD, 16'd1);
        write_reg(CFG_STEREO, 16'd1);
        write_reg(CFG_BLOG2, 16'd1);
      end else if (seg == 1) begin
        write_reg(CFG_PERIOD, 16'd65280);
        write_reg(CFG_STEREO, 16'd0);
        write_reg(CFG_BLOG2, 16'd10);
      end else begin
        write_reg(CFG_PERIOD, pick_period());
        write_reg(CFG_STEREO, 16'($urandom_range(1)));
        write_reg(CFG_BLOG2, 16'($urandom_range(15)));
      end
      quiet = (seg == 3);
      repeat (BEATS_PER_SEGMENT) begin
        if ($urandom_range(99) < 12) begin
          send_beat(OP_LOAD, 8'($urandom()), rand_word(), 16'($urandom()), 16'($urandom()));
        end else begin
          send_sample(rand_audio(), rand_audio());
        end
      end
    end
    quiet = 1'b0;

    wait_idle();
    if (flanger.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
